### rtl/chm_pkg.sv
// ---------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map
// Transaction payloads, operation and status codes, hash constants and
// the controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package chm_pkg;

  // input transaction
  typedef struct packed {
    logic [1:0]         op;
    logic [30:0]        lookup_key;
    logic signed [31:0] value_in;
  } in_t;

  // result transaction
  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value_out;
    logic [31:0]        conflict_total;
  } out_t;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_GET    = 2'd2;

  // status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_FOUND     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // hash constants
  localparam int          PROD_W     = 45;
  localparam int          REM_W      = 18;
  localparam logic [13:0] HASH_MUL   = 14'd13579;
  localparam logic [13:0] HASH_ADD   = 14'd12345;
  localparam logic [17:0] HASH_PRIME = 18'd105943;

  // fold the product: top bits weigh 2^30 mod prime, result below 2^31
  localparam int          FOLD_LO    = 30;
  localparam int          FOLD_W     = 31;
  localparam logic [13:0] HASH_K30   = 14'd9519;

  // ceil(2^48 / prime): exact quotient of any 31-bit value
  localparam int          RCP_SHIFT  = 48;
  localparam logic [31:0] HASH_RCP   = 32'd2656852994;
  localparam int          QUO_W      = 15;

  // bucket remainder unit: bits retired per cycle and cycles per pass
  localparam int DIV_UNROLL = 3;
  localparam int B_STEPS    = REM_W / DIV_UNROLL;
  localparam int CNT_W      = 3;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic fold;
    logic rcp;
    logic mid;
    logic div_b;
    logic head;
    logic adv;
    logic hit;
    logic act;
    logic link;
    logic emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_last;
    logic node_nil;
    logic match;
    logic need_link;
  } sts_t;

  // one restoring remainder step
  function automatic logic [17:0] mod_step(input logic [17:0] rem, input logic b,
                                           input logic [17:0] div);
    logic [17:0] t;
    t = {rem[16:0], b};
    if (t >= div) begin
      t = t - div;
    end
    return t;
  endfunction

endpackage

### rtl/chained_hash_map.sv
// ---------------------------------------------------------------------------
// chained_hash_map: key/value table with separate chaining
// Each transaction hashes the key, walks the bucket's chain one node at a time
// and then acts on the table; an insert of a new key adds a link step.
// One transaction at a time; busy stays high until the result strobe.
// Synchronous reset empties all chains, zeroes the counter, bucket count 20.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ---------------------------------------------------------------------------
module chained_hash_map #(
  parameter int BUCKETS = 32,
  parameter int POOL    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  chm_pkg::in_t  in_item,
  input  logic          cfg_wr_en,
  input  logic [5:0]    cfg_wr_data,
  output logic          out_valid,
  output chm_pkg::out_t out_item
);
  import chm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  chm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // hash unit and table storage
  chm_datapath #(
    .BUCKETS (BUCKETS),
    .POOL    (POOL)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_item    (out_item)
  );

endmodule

### rtl/chm_ctrl.sv
// ---------------------------------------------------------------------------
// chm_ctrl: operation sequencer
// Steps each transaction through hash, chain walk, update and reply.
// ---------------------------------------------------------------------------
module chm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output chm_pkg::cmd_t cmd,
  input  chm_pkg::sts_t sts
);
  import chm_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_FOLD = 4'd2;
  localparam logic [3:0] S_RCP  = 4'd3;
  localparam logic [3:0] S_MID  = 4'd4;
  localparam logic [3:0] S_DIVB = 4'd5;
  localparam logic [3:0] S_HEAD = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_ACT  = 4'd9;
  localparam logic [3:0] S_LINK = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_RCP;
      end
      S_RCP: begin
        cmd.rcp   = 1'b1;
        state_nxt = S_MID;
      end
      S_MID: begin
        cmd.mid   = 1'b1;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        cmd.div_b = 1'b1;
        if (sts.div_last) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = sts.node_nil ? S_ACT : S_CMP;
      end
      S_CMP: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_ACT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_ACT: begin
        cmd.act = 1'b1;
        if (sts.need_link) begin
          state_nxt = S_LINK;
        end else begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LINK: begin
        cmd.link  = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

### rtl/chm_datapath.sv
// ---------------------------------------------------------------------------
// chm_datapath: hash unit, bucket heads, node store and result register
// Reduces the hash by folding and a reciprocal quotient, takes the bucket
// with a small remainder unit, walks the chain through the node memories
// and applies insert, remove or get.
// ---------------------------------------------------------------------------
module chm_datapath #(
  parameter int BUCKETS = 32,
  parameter int POOL    = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  chm_pkg::in_t  in_item,
  input  logic          cfg_wr_en,
  input  logic [5:0]    cfg_wr_data,
  input  chm_pkg::cmd_t cmd,
  output chm_pkg::sts_t sts,
  output logic          out_valid,
  output chm_pkg::out_t out_item
);
  import chm_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int AW = $clog2(POOL);
  localparam int NW = AW + 1;
  localparam logic [NW-1:0] NIL = NW'(POOL);
  localparam int BCW = (BW + 1 > 6) ? BW + 1 : 6;

  // configuration and transaction registers
  logic [5:0]        bcount_r;
  in_t               item_r;
  logic [PROD_W-1:0] sh_r;
  logic [FOLD_W-1:0] y_r;
  logic [QUO_W-1:0]  q_r;
  logic [REM_W-1:0]  rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [BW-1:0]     bkt_r;
  logic [NW-1:0]     node_r, prev_r, slot_r;
  logic [NW-1:0]     head_r [BUCKETS];
  logic [AW:0]       passed_r;
  logic              found_r;
  logic [31:0]       conflict_r;
  logic              out_valid_r;
  out_t              res_r;

  // node store
  logic [30:0]   node_key   [POOL];
  logic [31:0]   node_value [POOL];
  logic [NW-1:0] node_next  [POOL];
  logic [POOL-1:0] used_r;
  logic [30:0]   rd_key_r;
  logic [31:0]   rd_val_r;
  logic [NW-1:0] rd_next_r;

  // lowest free slot, registered
  logic [NW-1:0] free_slot_r, free_slot_c;
  logic          free_ok_r, free_ok_c;

  logic [BCW-1:0]   m_ext;
  logic [REM_W-1:0] div_c, rem_c;
  logic [PROD_W-1:0] sh_c;
  logic [FOLD_W-1:0] fold_c, sub_c;
  logic [63:0]      rcp_prod;
  logic [NW-1:0]    next_cl;
  logic [32:0]      sum_c;
  logic [31:0]      cnt_new;
  logic [AW:0]      add_c;
  logic             do_insert_new;
  out_t             res_c;

  // clamp bucket count into 1..BUCKETS
  always_comb begin
    m_ext = BCW'(bcount_r);
    if (bcount_r == 6'd0) m_ext = BCW'(1);
    else if (BCW'(bcount_r) > BCW'(BUCKETS)) m_ext = BCW'(BUCKETS);
  end

  // fold the product below 2^31, keeping its residue mod the prime
  assign fold_c = FOLD_W'(sh_r[PROD_W-1:FOLD_LO]) * FOLD_W'(HASH_K30)
                + FOLD_W'(sh_r[FOLD_LO-1:0]);

  // quotient by the prime through the reciprocal, then the residue
  assign rcp_prod = 64'(y_r) * 64'(HASH_RCP);
  assign sub_c    = y_r - FOLD_W'(q_r) * FOLD_W'(HASH_PRIME);

  // bucket remainder unit, several bits a cycle
  always_comb begin
    div_c = REM_W'(m_ext);
    rem_c = rem_r;
    sh_c  = sh_r;
    for (int i = 0; i < DIV_UNROLL; i++) begin
      rem_c = mod_step(rem_c, sh_c[PROD_W-1], div_c);
      sh_c  = {sh_c[PROD_W-2:0], 1'b0};
    end
  end

  // clamp a stored link
  assign next_cl = (rd_next_r < NIL) ? rd_next_r : NIL;

  // lowest free slot search
  always_comb begin
    free_slot_c = NIL;
    free_ok_c   = 1'b0;
    for (int i = POOL - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_slot_c = NW'(i);
        free_ok_c   = 1'b1;
      end
    end
  end

  assign do_insert_new = (item_r.op == OP_INSERT) && !found_r && free_ok_r;

  // saturating conflict update
  always_comb begin
    add_c = passed_r;
    if (item_r.op == OP_INSERT && !found_r && !free_ok_r) add_c = '0;
    sum_c   = {1'b0, conflict_r} + 33'(add_c);
    cnt_new = sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];
  end

  assign sts.div_last  = (cnt_r == CNT_W'(B_STEPS - 1));
  assign sts.node_nil  = (node_r == NIL);
  assign sts.match     = (rd_key_r == item_r.lookup_key);
  assign sts.need_link = do_insert_new;

  // hash, walk and bookkeeping registers
  always_ff @(posedge clk) begin
    free_slot_r <= free_slot_c;
    free_ok_r   <= free_ok_c;
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.mul) begin
      sh_r <= PROD_W'(item_r.lookup_key) * PROD_W'(HASH_MUL) + PROD_W'(HASH_ADD);
    end
    if (cmd.fold) begin
      y_r <= fold_c;
    end
    if (cmd.rcp) begin
      q_r <= rcp_prod[RCP_SHIFT +: QUO_W];
    end
    if (cmd.div_b) begin
      sh_r  <= sh_c;
      rem_r <= rem_c;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.mid) begin
      sh_r  <= {REM_W'(sub_c), {(PROD_W - REM_W){1'b0}}};
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (cmd.head) begin
      bkt_r    <= rem_r[BW-1:0];
      node_r   <= (head_r[rem_r[BW-1:0]] < NIL) ? head_r[rem_r[BW-1:0]] : NIL;
      prev_r   <= NIL;
      passed_r <= '0;
      found_r  <= 1'b0;
    end
    // advance one node; stop after the pool bound
    if (cmd.adv) begin
      passed_r <= passed_r + (AW + 1)'(1);
      prev_r   <= node_r;
      node_r   <= (passed_r == (AW + 1)'(POOL - 1)) ? NIL : next_cl;
    end
    if (cmd.hit) begin
      found_r <= 1'b1;
    end
    if (cmd.act) begin
      slot_r <= free_slot_r;
    end
  end

  // clocked node reads at the walk pointer
  always_ff @(posedge clk) begin
    rd_key_r  <= node_key[node_r[AW-1:0]];
    rd_val_r  <= node_value[node_r[AW-1:0]];
    rd_next_r <= node_next[node_r[AW-1:0]];
  end

  // node writes
  always_ff @(posedge clk) begin
    if (cmd.act && item_r.op == OP_INSERT) begin
      if (found_r) begin
        node_value[node_r[AW-1:0]] <= item_r.value_in;
      end else if (free_ok_r) begin
        node_key[free_slot_r[AW-1:0]]   <= item_r.lookup_key;
        node_value[free_slot_r[AW-1:0]] <= item_r.value_in;
      end
    end
    if (cmd.act && do_insert_new) begin
      node_next[free_slot_r[AW-1:0]] <= NIL;
    end else if (cmd.act && item_r.op == OP_REMOVE && found_r && prev_r != NIL) begin
      node_next[prev_r[AW-1:0]] <= next_cl;
    end else if (cmd.link && prev_r != NIL) begin
      node_next[prev_r[AW-1:0]] <= slot_r;
    end
  end

  // control state: heads, used flags, counter, config, strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) head_r[i] <= NIL;
      used_r      <= '0;
      conflict_r  <= '0;
      bcount_r    <= 6'd20;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_wr_en) bcount_r <= cfg_wr_data;
      if (cmd.act && item_r.op == OP_INSERT) conflict_r <= cnt_new;
      if (cmd.act && do_insert_new) used_r[free_slot_r[AW-1:0]] <= 1'b1;
      if (cmd.act && item_r.op == OP_REMOVE && found_r) begin
        used_r[node_r[AW-1:0]] <= 1'b0;
        if (prev_r == NIL) head_r[bkt_r] <= next_cl;
      end
      if (cmd.link && prev_r == NIL) head_r[bkt_r] <= slot_r;
    end
  end

  // result fields
  always_comb begin
    res_c.value_out      = '0;
    res_c.status         = ST_NOT_FOUND;
    res_c.conflict_total = (item_r.op == OP_INSERT) ? cnt_new : conflict_r;
    case (item_r.op)
      OP_INSERT: begin
        if (found_r)        res_c.status = ST_UPDATED;
        else if (free_ok_r) res_c.status = ST_INSERTED;
        else                res_c.status = ST_FULL;
      end
      OP_REMOVE: begin
        if (found_r) res_c.status = ST_REMOVED;
      end
      OP_GET: begin
        if (found_r) begin
          res_c.status    = ST_FOUND;
          res_c.value_out = rd_val_r;
        end
      end
      default: res_c.status = ST_NOT_FOUND;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.act) begin
      res_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = res_r;

endmodule
